// ===== sv/cnh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate noise hash package
// Constants, request and status types and the output encoder shared by the hash unit.
// ----------------------------------------------------------------------------
package cnh_pkg;

  localparam logic [31:0] MIX_K1 = 32'h68E3_1DA4;
  localparam logic [31:0] MIX_K2 = 32'hB529_7A4D;
  localparam logic [31:0] MIX_K3 = 32'h1B56_C4E9;
  localparam logic [31:0] FOLD_Y = 32'd198491317;
  localparam logic [31:0] FOLD_Z = 32'd6542989;

  localparam logic CMD_COORD = 1'b0;
  localparam logic CMD_SEQ   = 1'b1;

  localparam logic [1:0] DIMS_TWO   = 2'd2;
  localparam logic [1:0] DIMS_THREE = 2'd3;

  localparam logic [1:0] FMT_RAW = 2'd0;
  localparam logic [1:0] FMT_F32 = 2'd1;
  localparam logic [1:0] FMT_F64 = 2'd2;
  localparam logic [1:0] FMT_ALT = 2'd3;

  localparam logic [7:0]  F32_EXP_BIAS = 8'd104;
  localparam logic [10:0] F64_EXP_BIAS = 11'd991;
  localparam logic [31:0] SIGN_FLIP    = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] index;
    logic [31:0] seed;
    logic [1:0]  fmt;
  } cnh_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] seq_index;
  } cnh_fstat_t;

  function automatic logic [63:0] cnh_encode(input logic [31:0] h, input logic [1:0] fmt);
    logic [22:0] m;
    logic [31:0] n;
    logic [4:0]  pm;
    logic [4:0]  pn;
    logic [23:0] t32;
    logic [52:0] t64;
    logic [7:0]  e32;
    logic [10:0] e64;
    logic [63:0] r;
    m  = h[31:9];
    n  = h ^ SIGN_FLIP;
    pm = '0;
    pn = '0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) pm = 5'(i);
    end
    for (int i = 0; i < 32; i++) begin
      if (n[i]) pn = 5'(i);
    end
    t32 = {1'b0, m} << (5'd23 - pm);
    t64 = {21'b0, n} << (6'd52 - {1'b0, pn});
    e32 = {3'b0, pm} + F32_EXP_BIAS;
    e64 = {6'b0, pn} + F64_EXP_BIAS;
    unique case (fmt)
      FMT_F32: begin
        r = (m == '0) ? 64'd0 : {32'd0, 1'b0, e32, t32[22:0]};
      end
      FMT_F64: begin
        r = (n == '0) ? 64'd0 : {1'b0, e64, t64[51:0]};
      end
      FMT_RAW, FMT_ALT: begin
        r = {32'd0, h};
      end
      default: begin
        r = {32'd0, h};
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cnh_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate noise hash front end
// Accepts requests, folds the coordinates or takes the sequence counter, and
// hands a mixing request to the queue.
// ----------------------------------------------------------------------------
module cnh_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               sequence_seed_we_i,
  input  wire logic [31:0]        sequence_seed_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [1:0]         dims_i,
  input  wire logic [1:0]         out_format_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic [31:0]        seed_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output cnh_pkg::cnh_req_t       push_req_o,
  output cnh_pkg::cnh_fstat_t     stat_o
);
  import cnh_pkg::*;

  logic        cfg_seed_we;
  logic [31:0] seq_seed_q;
  logic [31:0] seq_index_q, seq_index_d;
  logic        valid_q, valid_d;
  logic [31:0] x_q, x_d;
  logic [31:0] yp_q, yp_d;
  logic [31:0] zp_q, zp_d;
  logic [31:0] seed_q, seed_d;
  logic [1:0]  fmt_q, fmt_d;
  logic        in_fire;
  logic        push_fire;
  logic [31:0] y_u;
  logic [31:0] z_u;

  assign cfg_seed_we = sequence_seed_we_i;
  assign in_ready_o  = !valid_q || push_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign push_fire   = valid_q && push_ready_i;
  assign y_u         = $unsigned(coord_y_i);
  assign z_u         = $unsigned(coord_z_i);

  always_comb begin
    seq_index_d = seq_index_q;
    x_d         = $unsigned(coord_x_i);
    yp_d        = (dims_i == DIMS_TWO || dims_i == DIMS_THREE) ? y_u * FOLD_Y : 32'd0;
    zp_d        = (dims_i == DIMS_THREE) ? z_u * FOLD_Z : 32'd0;
    seed_d      = seed_i;
    fmt_d       = out_format_i;
    if (command_i == CMD_SEQ) begin
      x_d    = seq_index_q;
      yp_d   = 32'd0;
      zp_d   = 32'd0;
      seed_d = seq_seed_q;
      if (in_fire) seq_index_d = seq_index_q + 32'd1;
    end
    if (in_fire) begin
      valid_d = 1'b1;
    end else if (push_fire) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      seq_index_q <= '0;
      seq_seed_q  <= '0;
    end else begin
      valid_q     <= valid_d;
      seq_index_q <= seq_index_d;
      if (cfg_seed_we) seq_seed_q <= sequence_seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= x_d;
      yp_q   <= yp_d;
      zp_q   <= zp_d;
      seed_q <= seed_d;
      fmt_q  <= fmt_d;
    end
  end

  assign push_valid_o     = valid_q;
  assign push_req_o.index = x_q + yp_q + zp_q;
  assign push_req_o.seed  = seed_q;
  assign push_req_o.fmt   = fmt_q;
  assign stat_o.busy      = valid_q;
  assign stat_o.seq_index = seq_index_q;

endmodule
`default_nettype wire

// ===== sv/cnh_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate noise hash request queue
// Two-entry queue that decouples the front end from the mixing pipeline.
// ----------------------------------------------------------------------------
module cnh_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  cnh_pkg::cnh_req_t push_req_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output cnh_pkg::cnh_req_t pop_req_o
);
  import cnh_pkg::*;

  cnh_req_t    mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_req_i;
  end

endmodule
`default_nettype wire

// ===== sv/cnh_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate noise hash back end
// Four-stage pipeline that mixes the index with the seed and encodes the
// result into the requested format.
// ----------------------------------------------------------------------------
module cnh_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         pop_valid_i,
  output logic              pop_ready_o,
  input  cnh_pkg::cnh_req_t pop_req_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [31:0]       raw_hash_o,
  output logic [63:0]       value_o
);
  import cnh_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        adv1, adv2, adv3, adv4;
  logic [31:0] p1_q, s1_q;
  logic [1:0]  f1_q, f2_q, f3_q;
  logic [31:0] b2_d, b2_q;
  logic [31:0] b3_q;
  logic [31:0] h_d;
  logic [31:0] raw_q;
  logic [63:0] value_q;
  logic [31:0] t_a, t_b, t_c;

  assign adv4        = !v4_q || out_ready_i;
  assign adv3        = !v3_q || adv4;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign pop_ready_o = adv1;

  always_comb begin
    t_a  = p1_q + s1_q;
    t_b  = (t_a ^ (t_a >> 8)) + MIX_K2;
    t_c  = t_b ^ (t_b << 8);
    b2_d = t_c;
    h_d  = b3_q ^ (b3_q >> 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= pop_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      p1_q <= pop_req_i.index * MIX_K1;
      s1_q <= pop_req_i.seed;
      f1_q <= pop_req_i.fmt;
    end
    if (adv2) begin
      b2_q <= b2_d;
      f2_q <= f1_q;
    end
    if (adv3) begin
      b3_q <= b2_q * MIX_K3;
      f3_q <= f2_q;
    end
    if (adv4) begin
      raw_q   <= h_d;
      value_q <= cnh_encode(h_d, f3_q);
    end
  end

  assign out_valid_o = v4_q;
  assign raw_hash_o  = raw_q;
  assign value_o     = value_q;

endmodule
`default_nettype wire

// ===== sv/coordinate_noise_hash_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate noise hash unit
// Hashes one to three signed coordinates, or the next value of an internal
// sequence counter, into a 32-bit noise value with optional IEEE encoding.
//
// A request is taken on in_valid_i and in_ready_o both high; a result leaves
// on out_valid_o and out_ready_i both high, one result per request, in order.
// The front end folds the coordinates (two constant multiplies) into a
// register, a two-entry queue follows, and the back end mixes and encodes in
// four stages, the last of which is the output register.
// One request is taken every cycle while the receiver keeps up; each constant
// multiplier is combinational and completes within its own register stage.
// When the receiver stalls, the back end holds, the queue fills and the
// front end then drops in_ready_o; nothing is lost.
// Reset clears the sequence counter and the sequence seed to zero and empties
// every stage. The user must write the seed through sequence_seed_we_i only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module coordinate_noise_hash_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               sequence_seed_we_i,
  input  wire logic [31:0]        sequence_seed_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [1:0]         dims_i,
  input  wire logic [1:0]         out_format_i,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  input  wire logic signed [31:0] coord_z_i,
  input  wire logic [31:0]        seed_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             raw_hash_o,
  output logic [63:0]             value_o
);
  import cnh_pkg::*;

  logic       push_valid;
  logic       push_ready;
  cnh_req_t   push_req;
  logic       pop_valid;
  logic       pop_ready;
  cnh_req_t   pop_req;
  cnh_fstat_t fstat;

  cnh_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sequence_seed_we_i (sequence_seed_we_i),
    .sequence_seed_i    (sequence_seed_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .dims_i             (dims_i),
    .out_format_i       (out_format_i),
    .coord_x_i          (coord_x_i),
    .coord_y_i          (coord_y_i),
    .coord_z_i          (coord_z_i),
    .seed_i             (seed_i),
    .push_valid_o       (push_valid),
    .push_ready_i       (push_ready),
    .push_req_o         (push_req),
    .stat_o             (fstat)
  );

  cnh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  cnh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_req_i   (pop_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .raw_hash_o  (raw_hash_o),
    .value_o     (value_o)
  );

  // A sequence request advances the counter by exactly one.
  a_seq_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_SEQ)
      |=> (fstat.seq_index == $past(fstat.seq_index) + 32'd1))
    else $error("sequence counter did not advance");

  // Coordinate requests leave the counter alone.
  a_seq_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o && command_i == CMD_SEQ)
      |=> $stable(fstat.seq_index))
    else $error("sequence counter changed without a sequence request");

  // The front end only refuses requests while it holds one the queue cannot take.
  a_front_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (fstat.busy && !push_ready))
    else $error("front end stalled without cause");

  // An accepted request always reaches the front end register.
  a_front_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> fstat.busy)
    else $error("accepted request not held by the front end");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coordinate noise hash unit testbench
// Sends coordinate and sequence requests through the valid/ready input and
// compares every result, field by field and in order, with a local model of
// the hash and of its float encodings. A directed table comes first. Some of
// its rows use seeds chosen so that the hash lands on a chosen value. Random
// phases follow, each under its own sequence seed and pacing of both sides.
// ----------------------------------------------------------------------------
module tb;
  import cnh_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int PER_PHASE     = 85;
  localparam int PLAN_ROWS     = 23;

  typedef enum logic [1:0] {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  dims;
    logic [1:0]  fmt;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] seed;
  } noise_req_t;

  typedef struct packed {
    logic [31:0] raw;
    logic [63:0] value;
  } noise_res_t;

  typedef struct packed {
    noise_req_t req;
    logic       typed;
    noise_res_t want;
  } plan_row_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               sequence_seed_we_i = 1'b0;
  logic [31:0]        sequence_seed_i    = '0;
  logic               in_valid_i         = 1'b0;
  logic               in_ready_o;
  logic               command_i          = 1'b0;
  logic [1:0]         dims_i             = '0;
  logic [1:0]         out_format_i       = '0;
  logic signed [31:0] coord_x_i          = '0;
  logic signed [31:0] coord_y_i          = '0;
  logic signed [31:0] coord_z_i          = '0;
  logic [31:0]        seed_i             = '0;
  logic               out_valid_o;
  logic               out_ready_i        = 1'b0;
  logic [31:0]        raw_hash_o;
  logic [63:0]        value_o;

  logic [31:0]  seq_counter    = '0;
  logic [31:0]  seq_seed_model = '0;
  noise_res_t   expected_hashes[$];
  pace_e        pace           = PACE_NONE;
  int unsigned  mismatches     = 0;
  int unsigned  results_checked = 0;
  int unsigned  requests_sent  = 0;
  int unsigned  seq_requests   = 0;
  int unsigned  seed_writes    = 0;
  int unsigned  stall_cycles   = 0;

  // Rows marked typed take their seed from aim_seed, so that the hash is the
  // value in the row and the encoding can be read off directly.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{'{CMD_SEQ, 2'd1, FMT_RAW, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_SEQ, 2'd3, FMT_F32, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_SEQ, 2'd0, FMT_F64, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h1234_5678},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_SEQ, 2'd2, FMT_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd0, FMT_RAW, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd1, FMT_F32, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd2, FMT_F64, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_0000},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd3, FMT_ALT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd3, FMT_RAW, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd3, FMT_F64, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd2, FMT_F32, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001},
      1'b0, '{32'h0, 64'h0}},
    '{'{CMD_COORD, 2'd1, FMT_F32, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000},
      1'b1, '{32'h0000_0000, 64'h0000_0000_0000_0000}},
    '{'{CMD_COORD, 2'd0, FMT_F32, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
      1'b1, '{32'h0000_01FF, 64'h0000_0000_0000_0000}},
    '{'{CMD_COORD, 2'd1, FMT_F32, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000},
      1'b1, '{32'h0000_0200, 64'h0000_0000_3400_0000}},
    '{'{CMD_COORD, 2'd0, FMT_F32, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      1'b1, '{32'h8000_0000, 64'h0000_0000_3F00_0000}},
    '{'{CMD_COORD, 2'd1, FMT_F32, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000},
      1'b1, '{32'hFFFF_FFFF, 64'h0000_0000_3F7F_FFFE}},
    '{'{CMD_COORD, 2'd1, FMT_F64, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
      1'b1, '{32'h8000_0000, 64'h0000_0000_0000_0000}},
    '{'{CMD_COORD, 2'd0, FMT_F64, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
      1'b1, '{32'h8000_0001, 64'h3DF0_0000_0000_0000}},
    '{'{CMD_COORD, 2'd1, FMT_F64, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000},
      1'b1, '{32'h0000_0000, 64'h3FE0_0000_0000_0000}},
    '{'{CMD_COORD, 2'd0, FMT_F64, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000},
      1'b1, '{32'h7FFF_FFFF, 64'h3FEF_FFFF_FFE0_0000}},
    '{'{CMD_COORD, 2'd1, FMT_RAW, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000},
      1'b1, '{32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF}},
    '{'{CMD_COORD, 2'd0, FMT_ALT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000},
      1'b1, '{32'hDEAD_BEEF, 64'h0000_0000_DEAD_BEEF}},
    '{'{CMD_SEQ, 2'd3, FMT_RAW, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
      1'b0, '{32'h0, 64'h0}}
  };

  coordinate_noise_hash_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .sequence_seed_we_i (sequence_seed_we_i),
    .sequence_seed_i    (sequence_seed_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .dims_i             (dims_i),
    .out_format_i       (out_format_i),
    .coord_x_i          (coord_x_i),
    .coord_y_i          (coord_y_i),
    .coord_z_i          (coord_z_i),
    .seed_i             (seed_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .raw_hash_o         (raw_hash_o),
    .value_o            (value_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] noise_mix(input logic [31:0] index, input logic [31:0] s);
    logic [31:0] b;
    b = index * MIX_K1;
    b = b + s;
    b = b ^ (b >> 8);
    b = b + MIX_K2;
    b = b ^ (b << 8);
    b = b * MIX_K3;
    b = b ^ (b >> 8);
    return b;
  endfunction

  function automatic logic [63:0] encode_single(input logic [31:0] h);
    logic [22:0] m;
    logic [31:0] frac;
    int          top;
    m   = h[31:9];
    top = 0;
    if (m == '0) return 64'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) top = i;
    end
    frac = {9'd0, m} << (23 - top);
    return {32'd0, 1'b0, 8'(top + 104), frac[22:0]};
  endfunction

  function automatic logic [63:0] encode_double(input logic [31:0] h);
    logic [63:0] n;
    logic [63:0] frac;
    int          top;
    n   = {32'd0, h ^ 32'h8000_0000};
    top = 0;
    if (n == '0) return 64'd0;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) top = i;
    end
    frac = n << (52 - top);
    return {1'b0, 11'(top + 991), frac[51:0]};
  endfunction

  function automatic noise_res_t predict_noise(input noise_req_t r);
    logic [31:0] idx;
    logic [31:0] h;
    noise_res_t  res;
    if (r.cmd == CMD_SEQ) begin
      h           = noise_mix(seq_counter, seq_seed_model);
      seq_counter = seq_counter + 32'd1;
    end else begin
      idx = r.x;
      if (r.dims >= DIMS_TWO) idx = idx + r.y * FOLD_Y;
      if (r.dims == DIMS_THREE) idx = idx + r.z * FOLD_Z;
      h = noise_mix(idx, r.seed);
    end
    res.raw = h;
    case (r.fmt)
      FMT_F32: begin
        res.value = encode_single(h);
      end
      FMT_F64: begin
        res.value = encode_double(h);
      end
      default: begin
        res.value = {32'd0, h};
      end
    endcase
    return res;
  endfunction

  // With a zero index the mix reduces to a bijection of the seed, so running
  // it backwards gives the seed that produces a chosen hash.
  function automatic logic [31:0] aim_seed(input logic [31:0] target);
    logic [31:0] b;
    logic [31:0] inv;
    inv = MIX_K3;
    repeat (5) inv = inv * (32'd2 - MIX_K3 * inv);
    b = target ^ (target >> 8) ^ (target >> 16) ^ (target >> 24);
    b = b * inv;
    b = b ^ (b << 8) ^ (b << 16) ^ (b << 24);
    b = b - MIX_K2;
    b = b ^ (b >> 8) ^ (b >> 16) ^ (b >> 24);
    return b;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic issue_request(input noise_req_t r, input logic typed, input noise_res_t want);
    int unsigned gap;
    int unsigned pct;
    pct = (pace == PACE_SENDER) ? 84 : (pace == PACE_BOTH) ? 17 : 0;
    gap = 0;
    while (gap < 100 && $urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i    <= r.cmd;
    dims_i       <= r.dims;
    out_format_i <= r.fmt;
    coord_x_i    <= r.x;
    coord_y_i    <= r.y;
    coord_z_i    <= r.z;
    seed_i       <= r.seed;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_hashes.push_back(typed ? want : predict_noise(r));
    requests_sent++;
    if (r.cmd == CMD_SEQ) seq_requests++;
  endtask

  task automatic load_seed(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sequence_seed_we_i <= 1'b1;
    sequence_seed_i    <= v;
    @(posedge clk_i);
    sequence_seed_we_i <= 1'b0;
    seq_seed_model = v;
    seed_writes++;
  endtask

  always @(posedge clk_i) begin : result_check
    noise_res_t want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(0, 99) >=
                      ((pace == PACE_RECEIVER) ? 84 : (pace == PACE_BOTH) ? 17 : 0));
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("unrequested result", {32'd0, raw_hash_o}, 64'd0);
        end else begin
          want = expected_hashes.pop_front();
          results_checked++;
          if (raw_hash_o !== want.raw) begin
            report_mismatch("raw_hash", {32'd0, raw_hash_o}, {32'd0, want.raw});
          end
          if (value_o !== want.value) begin
            report_mismatch("value", value_o, want.value);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", expected_hashes.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    noise_req_t  r;
    noise_res_t  none;
    logic [31:0] phase_seed [RANDOM_PHASES];
    pace_e       phase_pace [RANDOM_PHASES];
    phase_seed = '{32'hFFFF_FFFF, $urandom, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
                   $urandom};
    phase_pace = '{PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH, PACE_SENDER,
                   PACE_RECEIVER};
    none = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      r = directed_plan[i].req;
      if (directed_plan[i].typed) r.seed = aim_seed(directed_plan[i].want.raw);
      issue_request(r, directed_plan[i].typed, directed_plan[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_seed(phase_seed[p]);
      pace = phase_pace[p];
      for (int k = 0; k < PER_PHASE; k++) begin
        r.cmd  = ($urandom_range(0, 3) == 0) ? CMD_SEQ : CMD_COORD;
        r.dims = 2'($urandom_range(0, 3));
        r.fmt  = 2'($urandom_range(0, 3));
        r.x    = pick_coord();
        r.y    = pick_coord();
        r.z    = pick_coord();
        r.seed = ($urandom_range(0, 7) == 0) ? pick_coord() : $urandom;
        // Now and then steer the hash close to the encoding boundaries.
        if (r.cmd == CMD_COORD && $urandom_range(0, 9) == 0) begin
          r.dims = 2'($urandom_range(0, 1));
          r.x    = '0;
          r.seed = aim_seed(($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0) ^
                            ($urandom >> $urandom_range(0, 31)));
        end
        issue_request(r, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests (%0d sequential) across %0d seed writes and four pacing modes.",
             requests_sent, seq_requests, seed_writes);
    $display("Compared %0d results field by field; %0d mismatches found.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
